>>> rtl/temporal_pixel_accumulator_unit_assert.svh
// assertion macros shared by the temporal pixel accumulator rtl
// expects signals named clock and reset in the module that uses them
`ifndef TEMPORAL_PIXEL_ACCUMULATOR_UNIT_ASSERT_SVH
`define TEMPORAL_PIXEL_ACCUMULATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TPA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("temporal pixel accumulator assertion failed");

// next-cycle implication
`define TPA_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("temporal pixel accumulator assertion failed");

`endif

>>> rtl/tpa_pkg.sv
// shared types, constants and register codes of the temporal pixel accumulator
// no dependencies
`timescale 1ns / 1ps

package tpa_pkg;

   localparam int HISTORY_DEFAULT     = 4;
   localparam int PIXEL_COUNT_DEFAULT = 65536;
   localparam int WEIGHT_SHIFT        = 16;
   localparam int CHAN_W              = 8;
   localparam int WEIGHT_W            = 16;
   localparam int MAX_LANES           = 4;
   localparam int INDEX_W             = 16;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 64;
   localparam int REQ_TDATA_W         = 40;
   localparam int RSP_TDATA_W         = 24;

   localparam logic [CHAN_W-1:0]     CHAN_MAX             = 8'd255;
   localparam logic [CSR_DATA_W-1:0] STILL_WEIGHTS_RESET  = 64'h4000_4000_4000_4000;
   localparam logic [CSR_DATA_W-1:0] MOVING_WEIGHTS_RESET = 64'h0;

   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } rgb_type;

   typedef logic [MAX_LANES-1:0][WEIGHT_W-1:0] weight_set_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLEND_ENABLE   = 2'd0,
      CSR_STILL_WEIGHTS  = 2'd1,
      CSR_MOVING_WEIGHTS = 2'd2
   } csr_index_type;

endpackage

>>> rtl/tpa_ram.sv
// generic simple dual port ram, one write port and one registered read port
// read returns the contents before a write in the same cycle; no dependencies
`timescale 1ns / 1ps

module tpa_ram #(
   parameter  int WIDTH = 24,
   parameter  int DEPTH = 65536,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tpa_index.sv
// two pipeline stages that fold the pixel index into the frame size
// reciprocal multiply then one correcting subtract; uses tpa_pkg
`timescale 1ns / 1ps

module tpa_index
   import tpa_pkg::*;
#(
   parameter  int HISTORY     = HISTORY_DEFAULT,
   parameter  int PIXEL_COUNT = PIXEL_COUNT_DEFAULT,
   localparam int SW          = $clog2(HISTORY),
   localparam int AW          = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [INDEX_W-1:0] in_index,
   input  rgb_type            in_color,
   input  logic [SW-1:0]      in_slot,
   input  logic               in_blend,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [AW-1:0]      out_pix,
   output rgb_type            out_color,
   output logic [SW-1:0]      out_slot,
   output logic               out_blend
);

   localparam int             CW    = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
   localparam logic [32:0]    RECIP = 33'((64'd1 << 32) / PIXEL_COUNT);

   // stage 1: approximate quotient
   logic                 v1_ff;
   logic [INDEX_W-1:0]   x1_ff;
   logic [INDEX_W-1:0]   q1_ff;
   rgb_type              c1_ff;
   logic [SW-1:0]        s1_ff;
   logic                 b1_ff;

   // stage 2: folded index
   logic                 v2_ff;
   logic [AW-1:0]        p2_ff;
   rgb_type              c2_ff;
   logic [SW-1:0]        s2_ff;
   logic                 b2_ff;

   logic                 ready1;
   logic                 ready2;
   logic [INDEX_W+32:0]  q_prod;
   logic [INDEX_W-1:0]   q_in;
   logic [INDEX_W+CW-1:0] qn_prod;
   logic [INDEX_W-1:0]   rem;
   logic [CW-1:0]        rem_w;
   logic [CW-1:0]        fix;
   logic [AW-1:0]        pix_in;

   assign ready2   = !v2_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   assign q_prod = (INDEX_W + 33)'(in_index) * (INDEX_W + 33)'(RECIP);
   assign q_in   = q_prod[INDEX_W+31:32];

   assign qn_prod = (INDEX_W + CW)'(q1_ff) * (INDEX_W + CW)'(PIXEL_COUNT);
   assign rem     = x1_ff - qn_prod[INDEX_W-1:0];
   assign rem_w   = CW'(rem);
   assign fix     = (rem_w >= CW'(PIXEL_COUNT)) ? rem_w - CW'(PIXEL_COUNT) : rem_w;
   assign pix_in  = fix[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= in_valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         x1_ff <= in_index;
         q1_ff <= q_in;
         c1_ff <= in_color;
         s1_ff <= in_slot;
         b1_ff <= in_blend;
      end
      if (ready2 && v1_ff) begin
         p2_ff <= pix_in;
         c2_ff <= c1_ff;
         s2_ff <= s1_ff;
         b2_ff <= b1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_pix   = p2_ff;
   assign out_color = c2_ff;
   assign out_slot  = s2_ff;
   assign out_blend = b2_ff;

endmodule

>>> rtl/tpa_history.sv
// history banks, one ram per frame slot, with the clearing pass after reset
// reads all banks and, when blend is on, writes the current slot in one stage; uses tpa_pkg, tpa_ram
`timescale 1ns / 1ps
`include "temporal_pixel_accumulator_unit_assert.svh"

module tpa_history
   import tpa_pkg::*;
#(
   parameter  int HISTORY     = HISTORY_DEFAULT,
   parameter  int PIXEL_COUNT = PIXEL_COUNT_DEFAULT,
   localparam int SW          = $clog2(HISTORY),
   localparam int AW          = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   output logic                   clearing,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [AW-1:0]          in_pix,
   input  rgb_type                in_color,
   input  logic [SW-1:0]          in_slot,
   input  logic                   in_blend,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rgb_type                out_color,
   output logic [SW-1:0]          out_slot,
   output logic                   out_blend,
   output rgb_type [HISTORY-1:0]  out_bank
);

   localparam logic [AW-1:0] LAST_PIX = AW'(PIXEL_COUNT - 1);

   logic              clear_ff;
   logic [AW-1:0]     clear_cnt_ff;
   logic              v3_ff;
   rgb_type           c3_ff;
   logic [SW-1:0]     s3_ff;
   logic              b3_ff;

   logic              advance;
   logic [AW-1:0]     wr_addr;
   rgb_type           wr_data;
   logic [HISTORY-1:0] bank_we;

   assign in_ready = !clear_ff && (!v3_ff || out_ready);
   assign advance  = in_valid && in_ready;
   assign wr_addr  = clear_ff ? clear_cnt_ff : in_pix;
   assign wr_data  = clear_ff ? rgb_type'('0) : in_color;
   assign clearing = clear_ff;

   for (genvar k = 0; k < HISTORY; k++) begin : g_bank
      assign bank_we[k] = clear_ff || (advance && in_blend && (in_slot == SW'(k)));

      tpa_ram #(
         .WIDTH ($bits(rgb_type)),
         .DEPTH (PIXEL_COUNT)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_we[k]),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (advance),
         .rd_addr (in_pix),
         .rd_data (out_bank[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         v3_ff        <= 1'b0;
      end else begin
         if (clear_ff) begin
            if (clear_cnt_ff == LAST_PIX) begin
               clear_ff <= 1'b0;
            end else begin
               clear_cnt_ff <= clear_cnt_ff + AW'(1);
            end
         end
         if (!v3_ff || out_ready) begin
            v3_ff <= advance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c3_ff <= in_color;
         s3_ff <= in_slot;
         b3_ff <= in_blend;
      end
   end

   assign out_valid = v3_ff;
   assign out_color = c3_ff;
   assign out_slot  = s3_ff;
   assign out_blend = b3_ff;

   `TPA_ASSERT_IMP(a_one_bank_write, !clear_ff, $onehot0(bank_we))
   `TPA_ASSERT_IMP(a_clear_ends_at_last, $fell(clear_ff), $past(clear_cnt_ff == LAST_PIX))
   `TPA_ASSERT_NXT(a_clear_no_issue, clear_ff, !v3_ff || $past(v3_ff))

endmodule

>>> rtl/tpa_blend.sv
// weighted blend over the history slots: select, multiply, sum and saturate,
// or pass the colour through when blend is off; three pipeline stages; uses tpa_pkg
`timescale 1ns / 1ps

module tpa_blend
   import tpa_pkg::*;
#(
   parameter  int HISTORY = HISTORY_DEFAULT,
   localparam int SW      = $clog2(HISTORY)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  weight_set_type        still_weights,
   input  weight_set_type        moving_weights,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rgb_type               in_color,
   input  logic [SW-1:0]         in_slot,
   input  logic                  in_blend,
   input  rgb_type [HISTORY-1:0] in_bank,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rgb_type               out_color
);

   localparam int PROD_W = CHAN_W + WEIGHT_W;
   localparam int ACC_W  = PROD_W + $clog2(HISTORY) + 1;
   localparam int SH_W   = ACC_W - WEIGHT_SHIFT;
   localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (WEIGHT_SHIFT - 1);

   typedef logic [HISTORY-1:0][PROD_W-1:0] prod_set_type;

   function automatic logic [SW-1:0] older_slot(input logic [SW-1:0] slot, input int j);
      logic [SW:0] s;
      s = (SW + 1)'(slot) + (SW + 1)'(HISTORY - j);
      if (s >= (SW + 1)'(HISTORY)) begin
         s = s - (SW + 1)'(HISTORY);
      end
      return s[SW-1:0];
   endfunction

   function automatic chan_type blend_sum(input prod_set_type p);
      logic [ACC_W-1:0] acc;
      logic [SH_W-1:0]  sh;
      acc = ROUND;
      for (int j = 0; j < HISTORY; j++) begin
         acc = acc + ACC_W'(p[j]);
      end
      sh = acc[ACC_W-1:WEIGHT_SHIFT];
      if (sh > SH_W'(CHAN_MAX)) begin
         return CHAN_MAX;
      end
      return sh[CHAN_W-1:0];
   endfunction

   // stage 4: colours and chosen weights
   logic                              v4_ff;
   rgb_type [HISTORY-1:0]             c4_ff;
   logic [HISTORY-1:0][WEIGHT_W-1:0]  w4_ff;
   logic                              b4_ff;

   // stage 5: products
   logic                              v5_ff;
   prod_set_type                      pr5_ff;
   prod_set_type                      pg5_ff;
   prod_set_type                      pb5_ff;
   rgb_type                           pc5_ff;
   logic                              b5_ff;

   // stage 6: result
   logic                              v6_ff;
   rgb_type                           o6_ff;

   logic                              ready4;
   logic                              ready5;
   logic                              ready6;
   logic                              same;
   weight_set_type                    w_sel;
   rgb_type [HISTORY-1:0]             c4_in;
   prod_set_type                      pr_in;
   prod_set_type                      pg_in;
   prod_set_type                      pb_in;
   rgb_type                           o6_in;

   assign ready6   = !v6_ff || out_ready;
   assign ready5   = !v5_ff || ready6;
   assign ready4   = !v4_ff || ready5;
   assign in_ready = ready4;

   assign same  = (in_bank[in_slot] == in_color);
   assign w_sel = same ? still_weights : moving_weights;

   for (genvar j = 0; j < HISTORY; j++) begin : g_lane
      if (j == 0) begin : g_newest
         assign c4_in[j] = in_color;
      end else begin : g_older
         assign c4_in[j] = in_bank[older_slot(in_slot, j)];
      end
      assign pr_in[j] = PROD_W'(c4_ff[j].red) * PROD_W'(w4_ff[j]);
      assign pg_in[j] = PROD_W'(c4_ff[j].green) * PROD_W'(w4_ff[j]);
      assign pb_in[j] = PROD_W'(c4_ff[j].blue) * PROD_W'(w4_ff[j]);
   end

   always_comb begin
      if (b5_ff) begin
         o6_in.red   = blend_sum(pr5_ff);
         o6_in.green = blend_sum(pg5_ff);
         o6_in.blue  = blend_sum(pb5_ff);
      end else begin
         o6_in = pc5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (ready4) begin
            v4_ff <= in_valid;
         end
         if (ready5) begin
            v5_ff <= v4_ff;
         end
         if (ready6) begin
            v6_ff <= v5_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready4 && in_valid) begin
         c4_ff <= c4_in;
         w4_ff <= w_sel[HISTORY-1:0];
         b4_ff <= in_blend;
      end
      if (ready5 && v4_ff) begin
         pr5_ff <= pr_in;
         pg5_ff <= pg_in;
         pb5_ff <= pb_in;
         pc5_ff <= c4_ff[0];
         b5_ff  <= b4_ff;
      end
      if (ready6 && v5_ff) begin
         o6_ff <= o6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_color = o6_ff;

endmodule

>>> rtl/temporal_pixel_accumulator_unit.sv
// top level of the temporal pixel accumulator: registers, slot pointer, pipeline
// uses tpa_pkg, tpa_index, tpa_history, tpa_blend and the assertion header
//
// channel  direction  handshake             payload
// req      in         req_tvalid/tready     tdata index, red, green, blue; tlast frame end
// rsp      out        rsp_tvalid/tready     tdata red, green, blue
// csr      in         csr_we                csr_index, csr_wdata
//
// one pixel per clock sustained while rsp_tready stays high, outside the clearing pass
// the index fold, the history ram read and the multiply-sum stages set the depth
// after reset a clearing pass zeroes all PIXEL_COUNT entries of the history rams;
// req_tready stays low during it while csr writes are still taken
// a stalled response backs up through the stage valids without loss
`timescale 1ns / 1ps
`include "temporal_pixel_accumulator_unit_assert.svh"

module temporal_pixel_accumulator_unit
   import tpa_pkg::*;
#(
   parameter int HISTORY     = HISTORY_DEFAULT,
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // pixel_index[15:0], red_in[23:16], green_in[31:24], blue_in[39:32]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SW = $clog2(HISTORY);
   localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   logic              blend_ff;
   weight_set_type    still_ff;
   weight_set_type    moving_ff;
   logic [SW-1:0]     frame_slot_ff;
   logic [SW-1:0]     frame_slot_in;

   logic              req_accept;
   logic              clearing;
   rgb_type           req_color;

   logic              idx_in_ready;
   logic              idx_valid;
   logic [AW-1:0]     idx_pix;
   rgb_type           idx_color;
   logic [SW-1:0]     idx_slot;
   logic              idx_blend;
   logic              hist_in_ready;

   logic                  hist_valid;
   rgb_type               hist_color;
   logic [SW-1:0]         hist_slot;
   logic                  hist_blend;
   rgb_type [HISTORY-1:0] hist_bank;
   logic                  blend_in_ready;

   rgb_type           rsp_color;

   assign req_tready = idx_in_ready && !clearing;
   assign req_accept = req_tvalid && req_tready;

   assign req_color.red   = req_tdata[23:16];
   assign req_color.green = req_tdata[31:24];
   assign req_color.blue  = req_tdata[39:32];

   assign frame_slot_in = (frame_slot_ff == SW'(HISTORY - 1)) ? '0 : frame_slot_ff + SW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff      <= 1'b0;
         still_ff      <= STILL_WEIGHTS_RESET;
         moving_ff     <= MOVING_WEIGHTS_RESET;
         frame_slot_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_BLEND_ENABLE:   blend_ff  <= csr_wdata[0];
               CSR_STILL_WEIGHTS:  still_ff  <= csr_wdata;
               CSR_MOVING_WEIGHTS: moving_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_accept && req_tlast) begin
            frame_slot_ff <= frame_slot_in;
         end
      end
   end

   tpa_index #(
      .HISTORY     (HISTORY),
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_index (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && !clearing),
      .in_ready  (idx_in_ready),
      .in_index  (req_tdata[INDEX_W-1:0]),
      .in_color  (req_color),
      .in_slot   (frame_slot_ff),
      .in_blend  (blend_ff),
      .out_valid (idx_valid),
      .out_ready (hist_in_ready),
      .out_pix   (idx_pix),
      .out_color (idx_color),
      .out_slot  (idx_slot),
      .out_blend (idx_blend)
   );

   tpa_history #(
      .HISTORY     (HISTORY),
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_history (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .in_valid  (idx_valid),
      .in_ready  (hist_in_ready),
      .in_pix    (idx_pix),
      .in_color  (idx_color),
      .in_slot   (idx_slot),
      .in_blend  (idx_blend),
      .out_valid (hist_valid),
      .out_ready (blend_in_ready),
      .out_color (hist_color),
      .out_slot  (hist_slot),
      .out_blend (hist_blend),
      .out_bank  (hist_bank)
   );

   tpa_blend #(
      .HISTORY (HISTORY)
   ) u_blend (
      .clock          (clock),
      .reset          (reset),
      .still_weights  (still_ff),
      .moving_weights (moving_ff),
      .in_valid       (hist_valid),
      .in_ready       (blend_in_ready),
      .in_color       (hist_color),
      .in_slot        (hist_slot),
      .in_blend       (hist_blend),
      .in_bank        (hist_bank),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_color      (rsp_color)
   );

   assign rsp_tdata = {rsp_color.blue, rsp_color.green, rsp_color.red};

   `TPA_ASSERT_IMP(a_no_request_while_clearing, clearing, !req_tready)
   `TPA_ASSERT_NXT(a_slot_moves_on_frame_end, !(req_accept && req_tlast), $stable(frame_slot_ff))
   `TPA_ASSERT_IMP(a_slot_in_range, 1'b1, frame_slot_ff <= SW'(HISTORY - 1))

endmodule

>>> tb/tb_top.sv
// self-checking testbench for temporal_pixel_accumulator_unit: a scoreboard class mirrors
// the four-frame history store and weighted blend, plain tasks drive requests and registers
// depends on tpa_pkg and the rtl of the accumulator
`timescale 1ns / 1ps

module tb_top;
   import tpa_pkg::*;

   localparam int HIST = HISTORY_DEFAULT;
   localparam int PIX = PIXEL_COUNT_DEFAULT;
   localparam int STALL_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_OFF_CYCLES = 500;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_PIXELS = 220;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNKNOWN_INDEX = 2'd3;
   localparam logic [CSR_DATA_W-1:0] WEIGHTS_ALL_ONES = '1;
   localparam logic [CSR_DATA_W-1:0] WEIGHTS_ZERO = '0;

   class pixel_blend_checker;
      bit [23:0] history [HIST*PIX];
      bit [1:0] slot;
      bit blend_on;
      bit [63:0] still_w;
      bit [63:0] moving_w;
      rgb_type expected_colors [$];
      int mismatches;
      int checked;
      int still_blends;
      int moving_blends;
      int passed_through;

      function new();
         foreach (history[i]) history[i] = '0;
         slot = '0;
         blend_on = 1'b0;
         still_w = STILL_WEIGHTS_RESET;
         moving_w = MOVING_WEIGHTS_RESET;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_BLEND_ENABLE: begin
               blend_on = val[0];
            end
            CSR_STILL_WEIGHTS: begin
               still_w = val;
            end
            CSR_MOVING_WEIGHTS: begin
               moving_w = val;
            end
            default: begin
            end
         endcase
      endfunction

      function bit [23:0] stored_color(bit [15:0] idx);
         return history[int'(slot) * PIX + int'(idx) % PIX];
      endfunction

      function chan_type weighted_channel(bit [3:0][7:0] chans, bit [63:0] w);
         bit [63:0] acc;
         acc = 64'd1 << (WEIGHT_SHIFT - 1);
         for (int j = 0; j < HIST; j++) begin
            acc += 64'(chans[j]) * 64'(w[16*j +: 16]);
         end
         acc = acc >> WEIGHT_SHIFT;
         return (acc > 64'(CHAN_MAX)) ? CHAN_MAX : acc[7:0];
      endfunction

      function void note_request(bit [15:0] idx, rgb_type color, bit last);
         int base;
         int s;
         bit same;
         bit [63:0] w;
         bit [23:0] entry;
         bit [3:0][7:0] reds;
         bit [3:0][7:0] greens;
         bit [3:0][7:0] blues;
         rgb_type blended;
         if (blend_on) begin
            base = int'(slot) * PIX + int'(idx) % PIX;
            same = (history[base] == color);
            history[base] = color;
            for (int j = 0; j < HIST; j++) begin
               s = (int'(slot) + HIST - j) % HIST;
               entry = history[s * PIX + int'(idx) % PIX];
               reds[j] = entry[23:16];
               greens[j] = entry[15:8];
               blues[j] = entry[7:0];
            end
            w = same ? still_w : moving_w;
            blended.red = weighted_channel(reds, w);
            blended.green = weighted_channel(greens, w);
            blended.blue = weighted_channel(blues, w);
            if (same) still_blends++;
            else moving_blends++;
            expected_colors = {expected_colors, blended};
         end else begin
            passed_through++;
            expected_colors = {expected_colors, color};
         end
         if (last) slot = 2'((int'(slot) + 1) % HIST);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 50) $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_response(logic [RSP_TDATA_W-1:0] tdata);
         rgb_type want;
         if (expected_colors.size() == 0) begin
            report_mismatch($sformatf("response %h with no request pending", tdata));
         end else begin
            want = expected_colors.pop_front();
            checked++;
            if (tdata[7:0] !== want.red)
               report_mismatch($sformatf("red %h, expected %h", tdata[7:0], want.red));
            if (tdata[15:8] !== want.green)
               report_mismatch($sformatf("green %h, expected %h", tdata[15:8], want.green));
            if (tdata[23:16] !== want.blue)
               report_mismatch($sformatf("blue %h, expected %h", tdata[23:16], want.blue));
         end
      endtask

      task check_leftovers();
         if (expected_colors.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_colors.size()));
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pixel_blend_checker blend_check = new();
   int burst_left = 0;
   bit gapless = 1'b0;
   bit hold_off = 1'b0;
   int sent_pixels = 0;

   temporal_pixel_accumulator_unit uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      blend_check.write_register(idx, val);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task idle_sender(int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task send_pixel(bit [15:0] idx, rgb_type color, bit last);
      req_tvalid <= 1'b1;
      req_tdata <= {color.blue, color.green, color.red, idx};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      blend_check.note_request(idx, color, last);
      sent_pixels++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         idle_sender((gapless || hold_off) ? 0 : $urandom_range(1, 6));
      end
   endtask

   task drain();
      idle_sender(1);
      while (blend_check.expected_colors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function bit [63:0] small_weights();
      bit [63:0] w;
      for (int j = 0; j < HIST; j++) w[16*j +: 16] = 16'($urandom_range(0, 16'h4000));
      return w;
   endfunction

   task random_frames(int count);
      int frame_len;
      int pick;
      bit [15:0] idx;
      rgb_type color;
      bit last;
      while (count > 0) begin
         frame_len = $urandom_range(1, 10);
         for (int k = 0; k < frame_len && count > 0; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) idx = 16'($urandom_range(0, 7));
            else if (pick < 80) idx = 16'hFFF8 + 16'($urandom_range(0, 7));
            else idx = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45) color = blend_check.stored_color(idx);
            else if (pick < 50) color = '0;
            else if (pick < 55) color = '1;
            else color = 24'($urandom);
            last = (k == frame_len - 1);
            // occasional noise with a random frame end
            if ($urandom_range(0, 19) == 0) last = 1'($urandom);
            send_pixel(idx, color, last);
            count--;
         end
      end
   endtask

   // response side: stall patterns chosen anew at random, one long hold-off
   initial begin
      int mode;
      int phase_cycle;
      int hold_left;
      bit hold_done;
      mode = 0;
      phase_cycle = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) blend_check.check_response(rsp_tdata);
         if (!hold_done && hold_left == 0 && blend_check.checked >= 400) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off = 1'b1;
         end
         phase_cycle++;
         if (phase_cycle % 64 == 0) mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
            if (hold_left == 0) begin
               hold_off = 1'b0;
               hold_done = 1'b1;
            end
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom);
               2: rsp_tready <= (phase_cycle % 4 != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // pass-through at reset settings, frame end still moves the slot
      gapless = 1'b1;
      send_pixel(16'h0000, 24'h000000, 1'b0);
      send_pixel(16'hFFFF, 24'hFFFFFF, 1'b0);
      send_pixel(16'h5A5A, 24'h12A53C, 1'b1);
      send_pixel(16'hA5A5, 24'hFF0080, 1'b1);
      drain();

      // blending with reset weights, unknown index ignored
      write_reg(CSR_BLEND_ENABLE, 64'd1);
      write_reg(CSR_UNKNOWN_INDEX, WEIGHTS_ALL_ONES);
      gapless = 1'b0;
      send_pixel(16'h0000, 24'h000000, 1'b0);
      send_pixel(16'h0000, 24'h102030, 1'b0);
      send_pixel(16'h0000, 24'h102030, 1'b0);
      send_pixel(16'hFFFF, 24'hFFFFFF, 1'b1);
      send_pixel(16'hFFFF, 24'hFFFFFF, 1'b0);
      send_pixel(16'hFFFF, 24'hFFFFFF, 1'b1);
      send_pixel(16'h0007, 24'h808080, 1'b1);
      send_pixel(16'h0007, 24'h808080, 1'b1);
      drain();

      // saturation with full-scale weights
      write_reg(CSR_STILL_WEIGHTS, WEIGHTS_ALL_ONES);
      write_reg(CSR_MOVING_WEIGHTS, WEIGHTS_ALL_ONES);
      send_pixel(16'hFFFF, 24'hFFFFFF, 1'b0);
      send_pixel(16'h1234, 24'h010203, 1'b1);
      send_pixel(16'h1234, 24'h010203, 1'b0);
      drain();

      // single-lane weights: newest only when moving, oldest only when still
      write_reg(CSR_STILL_WEIGHTS, 64'hFFFF_0000_0000_0000);
      write_reg(CSR_MOVING_WEIGHTS, 64'h0000_0000_0000_FFFF);
      send_pixel(16'h0000, 24'hABCDEF, 1'b0);
      send_pixel(16'h0000, 24'hABCDEF, 1'b1);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               write_reg(CSR_BLEND_ENABLE, 64'd1);
               write_reg(CSR_STILL_WEIGHTS, WEIGHTS_ALL_ONES);
               write_reg(CSR_MOVING_WEIGHTS, WEIGHTS_ALL_ONES);
            end
            1: begin
               write_reg(CSR_STILL_WEIGHTS, WEIGHTS_ZERO);
               write_reg(CSR_MOVING_WEIGHTS, WEIGHTS_ZERO);
            end
            2: begin
               write_reg(CSR_BLEND_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
               write_reg(CSR_STILL_WEIGHTS, {$urandom, $urandom});
               write_reg(CSR_MOVING_WEIGHTS, {$urandom, $urandom});
               write_reg(CSR_UNKNOWN_INDEX, {$urandom, $urandom});
            end
            3: begin
               write_reg(CSR_BLEND_ENABLE, 64'd1);
               write_reg(CSR_STILL_WEIGHTS, STILL_WEIGHTS_RESET);
               write_reg(CSR_MOVING_WEIGHTS, small_weights());
            end
            default: begin
               write_reg(CSR_BLEND_ENABLE, {$urandom, $urandom} | 64'd1);
               write_reg(CSR_STILL_WEIGHTS, ($urandom_range(0, 1) == 1) ?
                         {$urandom, $urandom} : small_weights());
               write_reg(CSR_MOVING_WEIGHTS, ($urandom_range(0, 1) == 1) ?
                         {$urandom, $urandom} : small_weights());
            end
         endcase
         gapless = ($urandom_range(0, 3) == 0);
         random_frames(PHASE_PIXELS);
         drain();
      end

      blend_check.check_leftovers();
      $display("run covered %0d pixels and %0d checked responses over several register settings",
               sent_pixels, blend_check.checked);
      $display("%0d still blends, %0d moving blends, %0d pass-through, %0d mismatches",
               blend_check.still_blends, blend_check.moving_blends,
               blend_check.passed_through, blend_check.mismatches);
      if (blend_check.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tpa_pkg.sv
rtl/tpa_ram.sv
rtl/tpa_index.sv
rtl/tpa_history.sv
rtl/tpa_blend.sv
rtl/temporal_pixel_accumulator_unit.sv
tb/tb_top.sv
